// File: src/salcd_pkg.sv
// Shared constants and types for the set-associative LRU cache directory.
`timescale 1ns / 1ps

package salcd_pkg;

   // Default geometry
   localparam int DEF_SETS      = 64;
   localparam int DEF_WAYS      = 4;
   localparam int DEF_ADDR_BITS = 24;

   // Port widths
   localparam int ADDR_W     = 24;
   localparam int OFFSET_W   = 4;
   localparam int INDEX_W    = 3;
   localparam int WAYS_W     = 3;
   localparam int RANK_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // Raw set index before wrapping: up to 2**INDEX_W - 1 bits
   localparam int IDX_RAW_W  = (1 << INDEX_W) - 1;
   localparam int IDX_LUT_N  = 1 << IDX_RAW_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WAYS_USED   = 2'd2;

   // Register reset values
   localparam logic [OFFSET_W-1:0] RST_OFFSET_BITS = 4'd2;
   localparam logic [INDEX_W-1:0]  RST_INDEX_BITS  = 3'd6;
   localparam logic [WAYS_W-1:0]   RST_WAYS_USED   = 3'd4;

   // Operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;

   // Largest reportable recency rank
   localparam logic [RANK_W-1:0] RANK_MAX = 2'd3;

   typedef struct packed {
      logic clear;    // write an empty row at the sweep address
      logic capture;  // latch the transaction and read its set
      logic update;   // compare, reorder the set, post the result
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;  // sweep address is at the last set
   } dp_status_type;

endpackage

// File: src/salcd_ctrl.sv
// Controller state machine: clear sweep, idle, lookup.
`timescale 1ns / 1ps

module salcd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output salcd_pkg::ctrl_cmd_type  cmd,
   input  salcd_pkg::dp_status_type status
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: src/salcd_datapath.sv
// Datapath: address split, directory memory, tag compare and LRU reorder.
`timescale 1ns / 1ps

module salcd_datapath #(
   parameter int SETS      = salcd_pkg::DEF_SETS,
   parameter int WAYS      = salcd_pkg::DEF_WAYS,
   parameter int ADDR_BITS = salcd_pkg::DEF_ADDR_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  salcd_pkg::ctrl_cmd_type             cmd,
   output salcd_pkg::dp_status_type            status,
   input  logic                                csr_we,
   input  logic [salcd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [salcd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_operation,
   input  logic [salcd_pkg::ADDR_W-1:0]        req_address,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [salcd_pkg::RANK_W-1:0]        rsp_hit_rank
);

   localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int RANK_IW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int AW_W    = $clog2(WAYS + 1);

   typedef logic [WAYS-1:0][ADDR_BITS:0] row_type;  // per way: {valid, tag}

   // Configuration registers
   logic [salcd_pkg::OFFSET_W-1:0] offset_bits_ff, offset_bits_in;
   logic [salcd_pkg::INDEX_W-1:0]  index_bits_ff, index_bits_in;
   logic [salcd_pkg::WAYS_W-1:0]   ways_used_ff, ways_used_in;

   always_comb begin
      offset_bits_in = offset_bits_ff;
      index_bits_in  = index_bits_ff;
      ways_used_in   = ways_used_ff;
      if (csr_we) begin
         case (csr_index)
            salcd_pkg::REG_OFFSET_BITS: offset_bits_in = csr_wdata;
            salcd_pkg::REG_INDEX_BITS:  index_bits_in  = csr_wdata[salcd_pkg::INDEX_W-1:0];
            salcd_pkg::REG_WAYS_USED:   ways_used_in   = csr_wdata[salcd_pkg::WAYS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= salcd_pkg::RST_OFFSET_BITS;
         index_bits_ff  <= salcd_pkg::RST_INDEX_BITS;
         ways_used_ff   <= salcd_pkg::RST_WAYS_USED;
      end else begin
         offset_bits_ff <= offset_bits_in;
         index_bits_ff  <= index_bits_in;
         ways_used_ff   <= ways_used_in;
      end
   end

   // Address split
   logic [ADDR_BITS-1:0]           addr_val;
   logic [ADDR_BITS-1:0]           above;
   logic [salcd_pkg::IDX_RAW_W-1:0] idx_raw;
   logic [SET_W-1:0]               set_lut [salcd_pkg::IDX_LUT_N];
   logic [SET_W-1:0]               set_sel;
   logic [ADDR_BITS-1:0]           tag_sel;

   for (genvar g = 0; g < salcd_pkg::IDX_LUT_N; g++) begin : g_set_lut
      assign set_lut[g] = SET_W'(g % SETS);
   end

   assign addr_val = ADDR_BITS'(req_address);
   assign above    = addr_val >> offset_bits_ff;
   assign idx_raw  = above[salcd_pkg::IDX_RAW_W-1:0]
                   & ~({salcd_pkg::IDX_RAW_W{1'b1}} << index_bits_ff);
   assign set_sel  = set_lut[idx_raw];
   assign tag_sel  = above >> index_bits_ff;

   // Captured transaction
   logic                 op_ff, op_in;
   logic [SET_W-1:0]     set_ff, set_in;
   logic [ADDR_BITS-1:0] tag_ff, tag_in;

   assign op_in  = cmd.capture ? req_operation : op_ff;
   assign set_in = cmd.capture ? set_sel : set_ff;
   assign tag_in = cmd.capture ? tag_sel : tag_ff;

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      set_ff <= set_in;
      tag_ff <= tag_in;
   end

   // Clear sweep counter
   logic [SET_W-1:0] clr_cnt_ff, clr_cnt_in;

   assign status.clear_last = (clr_cnt_ff == SET_W'(SETS - 1));
   assign clr_cnt_in = (cmd.clear && !status.clear_last) ? clr_cnt_ff + SET_W'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Directory memory: one row per set
   row_type          dir_mem [SETS];
   row_type          row_ff;
   row_type          row_new;
   logic             mem_we;
   logic [SET_W-1:0] mem_waddr;
   row_type          mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         dir_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.capture) begin
         row_ff <= dir_mem[set_sel];
      end
   end

   // Compare and reorder
   logic [AW_W-1:0]    act_ways;
   logic [WAYS-1:0]    match;
   logic               hit;
   logic [RANK_IW-1:0] rank;

   always_comb begin
      if (ways_used_ff == '0) begin
         act_ways = AW_W'(1);
      end else if (int'(ways_used_ff) > WAYS) begin
         act_ways = AW_W'(WAYS);
      end else begin
         act_ways = AW_W'(ways_used_ff);
      end
   end

   always_comb begin
      hit  = 1'b0;
      rank = '0;
      for (int i = 0; i < WAYS; i++) begin
         match[i] = row_ff[i][ADDR_BITS] && (row_ff[i][ADDR_BITS-1:0] == tag_ff)
                  && (i < int'(act_ways));
      end
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit  = 1'b1;
            rank = RANK_IW'(i);
         end
      end
   end

   always_comb begin
      if (hit) begin
         row_new[0] = row_ff[rank];
      end else begin
         row_new[0] = {1'b1, tag_ff};
      end
      for (int j = 1; j < WAYS; j++) begin
         if (hit) begin
            row_new[j] = (j <= int'(rank)) ? row_ff[j-1] : row_ff[j];
         end else begin
            row_new[j] = (j < int'(act_ways)) ? row_ff[j-1] : row_ff[j];
         end
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = set_ff;
      mem_wdata = row_new;
      if (cmd.clear) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else if (cmd.update) begin
         mem_we = hit || (op_ff == salcd_pkg::OP_LOAD);
      end
   end

   // Result registers
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [salcd_pkg::RANK_W-1:0] rsp_rank_ff, rsp_rank_in;

   assign rsp_valid_in = cmd.update;
   assign rsp_hit_in   = cmd.update ? hit : rsp_hit_ff;

   always_comb begin
      rsp_rank_in = rsp_rank_ff;
      if (cmd.update) begin
         if (!hit) begin
            rsp_rank_in = '0;
         end else if (int'(rank) > int'(salcd_pkg::RANK_MAX)) begin
            rsp_rank_in = salcd_pkg::RANK_MAX;
         end else begin
            rsp_rank_in = salcd_pkg::RANK_W'(rank);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hit_ff  <= rsp_hit_in;
      rsp_rank_ff <= rsp_rank_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_hit_rank = rsp_rank_ff;

endmodule

// File: src/set_assoc_cache_lru_directory_top.sv
// Top level of the set-associative LRU cache directory.
`timescale 1ns / 1ps

// Tag directory of a set-associative, write-through, no-write-allocate cache
// with true LRU order per set. A transaction is taken at a clock edge where
// start is high and busy is low; the set's row is read from the directory
// memory at that accepting edge. In the following cycle, with busy high, the
// active ways are compared, and the reordered row and the result are
// registered at its closing edge. The result (hit, recency rank) is then on
// the rsp_ ports for exactly one cycle, marked by rsp_valid. The receiver
// cannot stall, so results are never held. busy is low again while the
// result is shown, so a new transaction can be taken then, but not before
// the last one has passed through its registered memory read and its
// compare-and-write-back step. After reset the block sweeps the directory
// clear, one set per cycle, with busy high; configuration writes are taken
// at any time but should only be made while the block is idle.

module set_assoc_cache_lru_directory_top #(
   parameter int SETS      = salcd_pkg::DEF_SETS,
   parameter int WAYS      = salcd_pkg::DEF_WAYS,
   parameter int ADDR_BITS = salcd_pkg::DEF_ADDR_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_operation,
   input  logic [salcd_pkg::ADDR_W-1:0]     req_address,
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic [salcd_pkg::RANK_W-1:0]     rsp_hit_rank,
   input  logic                             csr_we,
   input  logic [salcd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [salcd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   salcd_pkg::ctrl_cmd_type  cmd;
   salcd_pkg::dp_status_type status;

   // Sequence the clear sweep and each transaction's read and update cycles
   salcd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // Hold the configuration, the directory rows and the result registers
   salcd_datapath #(
      .SETS      (SETS),
      .WAYS      (WAYS),
      .ADDR_BITS (ADDR_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_operation (req_operation),
      .req_address   (req_address),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_hit_rank  (rsp_hit_rank)
   );

endmodule

// File: src/salcd_checker.sv
// Port-level checker for the cache directory, bound to the top level.
`timescale 1ns / 1ps

module salcd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic                         rsp_hit,
   input logic [salcd_pkg::RANK_W-1:0] rsp_hit_rank
);

   logic accept;
   assign accept = start && !busy;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after an accepted transaction");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("result strobe missing two cycles after accept");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe on two consecutive cycles");

   a_miss_rank_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_hit_rank == '0))
      else $error("nonzero rank reported on a miss");

endmodule

bind set_assoc_cache_lru_directory_top salcd_checker u_salcd_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_hit      (rsp_hit),
   .rsp_hit_rank (rsp_hit_rank)
);
